@@ design/rvu_pkg.sv @@
// ----------------------------------------------------------------------------
// rvu_pkg
// shared widths and fixed-point constants of the refraction vector unit
// ----------------------------------------------------------------------------
`default_nettype none

package rvu_pkg;

   localparam int unsigned VEC_W = 16;
   localparam int unsigned IDX_W = 16;

   localparam int unsigned Q_FRAC = 24;
   localparam logic [24:0] Q24_ONE = 25'h100_0000;
   localparam logic [57:0] Q24_HALF = 58'h80_0000;
   localparam logic [IDX_W-1:0] IDX_MIN = 16'd1;

endpackage

`default_nettype wire

@@ design/rvu_if.sv @@
// ----------------------------------------------------------------------------
// rvu channel interfaces
// valid/ready channels for incident words and refracted words
// ----------------------------------------------------------------------------
`default_nettype none

interface rvu_req_if;
   import rvu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] in_dir_x;
   logic signed [VEC_W-1:0] in_dir_y;
   logic signed [VEC_W-1:0] in_dir_z;
   logic signed [VEC_W-1:0] norm_x;
   logic signed [VEC_W-1:0] norm_y;
   logic signed [VEC_W-1:0] norm_z;
   logic [IDX_W-1:0]        refr_index;

   modport source (
      output valid, in_dir_x, in_dir_y, in_dir_z, norm_x, norm_y, norm_z, refr_index,
      input  ready
   );
   modport sink (
      input  valid, in_dir_x, in_dir_y, in_dir_z, norm_x, norm_y, norm_z, refr_index,
      output ready
   );
endinterface

interface rvu_rsp_if;
   import rvu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] out_x;
   logic signed [VEC_W-1:0] out_y;
   logic signed [VEC_W-1:0] out_z;
   logic                    total_reflection;

   modport source (
      output valid, out_x, out_y, out_z, total_reflection,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, total_reflection,
      output ready
   );
endinterface

`default_nettype wire

@@ design/refraction_vector_unit.sv @@
// ----------------------------------------------------------------------------
// refraction_vector_unit
// pipelined snell refraction of a unit direction about a unit normal
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+--------------------------------------------------------
//  req_ch   | in  | incident direction, surface normal, refractive index
//  rsp_ch   | out | refracted direction, total reflection flag
//
//  one word enters per cycle while the pipeline is not stalled; the depth is set by the
//  bit-per-stage dividers and square roots (25, 25, 31 and FRAC_BITS+1 stages)
//  the whole pipeline advances together while the output register is empty
//  or being taken; a stall holds every stage in place
//  reset clears the valid chain only
// ----------------------------------------------------------------------------
`default_nettype none

module refraction_vector_unit #(
   parameter int FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   rvu_req_if.sink   req_ch,
   rvu_rsp_if.source rsp_ch
);
   import rvu_pkg::*;

   localparam int TN  = 25;
   localparam int P1  = 25;
   localparam int P2  = 31;
   localparam int FN  = FRAC_BITS + 1;
   localparam int NW  = 31 + FRAC_BITS;
   localparam int SHR = (2 * FRAC_BITS >= 24) ? 2 * FRAC_BITS - 24 : 0;
   localparam int SHL = (2 * FRAC_BITS < 24) ? 24 - 2 * FRAC_BITS : 0;
   localparam int LAT = 4 + (TN + 1) + (P1 + 1) + 7 + (P2 + 1) + (FN + 1) + 1;

   typedef struct packed {
      logic                   enter;
      logic [24:0]            c;
      logic [IDX_W-1:0]       idx;
      logic [2:0][VEC_W-1:0]  d;
      logic [2:0][VEC_W:0]    n;
   } ctx_type;

   logic en;
   logic [LAT-1:0] vld_ff, vld_in;

   // stage 1: products
   logic [2:0][31:0]      s1_p_ff, s1_p_in;
   logic [2:0][VEC_W-1:0] s1_d_ff, s1_d_in, s1_n_ff, s1_n_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [31:0]           s1_idx2_ff, s1_idx2_in;
   // stage 2: cosine
   ctx_type               s2_ctx_ff, s2_ctx_in;
   logic [31:0]           s2_idx2_ff, s2_idx2_in;
   // stage 3: cosine squared
   ctx_type               s3_ctx_ff, s3_ctx_in;
   logic [31:0]           s3_idx2_ff, s3_idx2_in;
   logic [24:0]           s3_cch_ff, s3_cch_in;
   // stage 4: sine squared
   ctx_type               s4_ctx_ff, s4_ctx_in;
   logic [31:0]           s4_idx2_ff, s4_idx2_in;
   logic [24:0]           s4_s_ff, s4_s_in;
   logic [40:0]           s4_sidx_ff, s4_sidx_in;
   logic                  s4_ovf_ff, s4_ovf_in;
   // divider for the entry ratio
   logic [31:0]           d1_rem_ff [0:TN], d1_rem_in [0:TN];
   logic [24:0]           d1_nb_ff  [0:TN], d1_nb_in  [0:TN];
   logic [24:0]           d1_quo_ff [0:TN], d1_quo_in [0:TN];
   logic [56:0]           d1_sii_ff [0:TN], d1_sii_in [0:TN];
   logic                  d1_ovf_ff [0:TN], d1_ovf_in [0:TN];
   logic [31:0]           d1_den_ff [0:TN], d1_den_in [0:TN];
   ctx_type               d1_ctx_ff [0:TN], d1_ctx_in [0:TN];
   // square root of k
   logic [49:0]           q1_x_ff    [0:P1], q1_x_in    [0:P1];
   logic [P1+1:0]         q1_rem_ff  [0:P1], q1_rem_in  [0:P1];
   logic [P1-1:0]         q1_root_ff [0:P1], q1_root_in [0:P1];
   logic                  q1_tir_ff  [0:P1], q1_tir_in  [0:P1];
   ctx_type               q1_ctx_ff  [0:P1], q1_ctx_in  [0:P1];
   // stage 7: index products
   ctx_type               s7_ctx_ff, s7_ctx_in;
   logic                  s7_tir_ff, s7_tir_in;
   logic [40:0]           s7_iq_ff, s7_iq_in, s7_ic_ff, s7_ic_in;
   logic [24:0]           s7_q_ff, s7_q_in;
   logic [2:0][32:0]      s7_idd_ff, s7_idd_in;
   // stage 8: normal weight and direction term
   logic [2:0][VEC_W:0]   s8_n_ff, s8_n_in;
   logic                  s8_tir_ff, s8_tir_in;
   logic [43:0]           s8_w_ff, s8_w_in;
   logic [2:0][45:0]      s8_dt_ff, s8_dt_in;
   // stage 9: weighted normal
   logic                  s9_tir_ff, s9_tir_in;
   logic [2:0][60:0]      s9_wn_ff, s9_wn_in;
   logic [2:0][45:0]      s9_dt_ff, s9_dt_in;
   // stage 10: magnitudes
   logic                  s10_tir_ff, s10_tir_in;
   logic [2:0]            s10_neg_ff, s10_neg_in;
   logic [2:0][60:0]      s10_mag_ff, s10_mag_in;
   // stage 11: shift amount
   logic                  s11_tir_ff, s11_tir_in, s11_zero_ff, s11_zero_in;
   logic [2:0]            s11_neg_ff, s11_neg_in;
   logic [2:0][60:0]      s11_mag_ff, s11_mag_in;
   logic [5:0]            s11_sh_ff, s11_sh_in;
   // stage 12: scaled magnitudes
   logic                  s12_tir_ff, s12_tir_in, s12_zero_ff, s12_zero_in;
   logic [2:0]            s12_neg_ff, s12_neg_in;
   logic [2:0][29:0]      s12_m_ff, s12_m_in;
   // stage 13: squares
   logic                  s13_tir_ff, s13_tir_in, s13_zero_ff, s13_zero_in;
   logic [2:0]            s13_neg_ff, s13_neg_in;
   logic [2:0][29:0]      s13_m_ff, s13_m_in;
   logic [2:0][59:0]      s13_sq_ff, s13_sq_in;
   // square root of the squared length
   logic [61:0]           q2_x_ff    [0:P2], q2_x_in    [0:P2];
   logic [P2+1:0]         q2_rem_ff  [0:P2], q2_rem_in  [0:P2];
   logic [P2-1:0]         q2_root_ff [0:P2], q2_root_in [0:P2];
   logic                  q2_tir_ff  [0:P2], q2_tir_in  [0:P2];
   logic                  q2_zero_ff [0:P2], q2_zero_in [0:P2];
   logic [2:0]            q2_neg_ff  [0:P2], q2_neg_in  [0:P2];
   logic [2:0][29:0]      q2_m_ff    [0:P2], q2_m_in    [0:P2];
   // dividers for the normalized components
   logic [2:0][30:0]      d2_rem_ff [0:FN], d2_rem_in [0:FN];
   logic [2:0][FN-1:0]    d2_nb_ff  [0:FN], d2_nb_in  [0:FN];
   logic [2:0][FN-1:0]    d2_quo_ff [0:FN], d2_quo_in [0:FN];
   logic [30:0]           d2_len_ff [0:FN], d2_len_in [0:FN];
   logic                  d2_tir_ff [0:FN], d2_tir_in [0:FN];
   logic                  d2_zero_ff[0:FN], d2_zero_in[0:FN];
   logic [2:0]            d2_neg_ff [0:FN], d2_neg_in [0:FN];
   // output register
   logic [2:0][VEC_W-1:0] out_v_ff, out_v_in;
   logic                  out_tir_ff, out_tir_in;

   assign en           = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign vld_in       = {vld_ff[LAT-2:0], req_ch.valid};

   // stages 1 to 4
   always_comb begin
      logic signed [33:0] dot;
      logic [33:0]        mdot;
      logic [47:0]        cw;
      logic [49:0]        cc;
      logic [24:0]        s;

      s1_d_in   = {req_ch.in_dir_z, req_ch.in_dir_y, req_ch.in_dir_x};
      s1_n_in   = {req_ch.norm_z, req_ch.norm_y, req_ch.norm_x};
      s1_idx_in = (req_ch.refr_index == '0) ? IDX_MIN : req_ch.refr_index;
      s1_idx2_in = 32'(s1_idx_in) * 32'(s1_idx_in);
      for (int i = 0; i < 3; i++) begin
         s1_p_in[i] = 32'($signed(s1_d_in[i]) * $signed(s1_n_in[i]));
      end

      dot = 34'($signed(s1_p_ff[0])) + 34'($signed(s1_p_ff[1]))
          + 34'($signed(s1_p_ff[2]));
      mdot = dot[33] ? 34'(-dot) : 34'(dot);
      cw   = (48'(mdot[32:0]) << SHL) >> SHR;
      s2_ctx_in.enter = dot[33];
      s2_ctx_in.c     = (cw > 48'(Q24_ONE)) ? Q24_ONE : cw[24:0];
      s2_ctx_in.idx   = s1_idx_ff;
      s2_ctx_in.d     = s1_d_ff;
      for (int i = 0; i < 3; i++) begin
         s2_ctx_in.n[i] = dot[33] ? 17'($signed(s1_n_ff[i])) : 17'(-17'($signed(s1_n_ff[i])));
      end
      s2_idx2_in = s1_idx2_ff;

      cc         = 50'(s2_ctx_ff.c) * 50'(s2_ctx_ff.c);
      s3_cch_in  = cc[48:24];
      s3_ctx_in  = s2_ctx_ff;
      s3_idx2_in = s2_idx2_ff;

      s          = Q24_ONE - s3_cch_ff;
      s4_s_in    = s;
      s4_sidx_in = 41'(s) * 41'(s3_ctx_ff.idx);
      s4_ovf_in  = 34'(s) >= 34'({s3_idx2_ff, 1'b0});
      s4_ctx_in  = s3_ctx_ff;
      s4_idx2_in = s3_idx2_ff;
   end

   // entry ratio divider, one quotient bit per stage
   always_comb begin
      logic [32:0] r2;
      logic [32:0] df;
      logic        ge;

      d1_rem_in[0] = 32'(s4_s_ff[24:1]);
      d1_nb_in[0]  = {s4_s_ff[0], 24'b0};
      d1_quo_in[0] = '0;
      d1_sii_in[0] = 57'(s4_sidx_ff) * 57'(s4_ctx_ff.idx);
      d1_ovf_in[0] = s4_ovf_ff;
      d1_den_in[0] = s4_idx2_ff;
      d1_ctx_in[0] = s4_ctx_ff;
      for (int j = 0; j < TN; j++) begin
         r2 = {d1_rem_ff[j], d1_nb_ff[j][24]};
         df = r2 - {1'b0, d1_den_ff[j]};
         ge = r2 >= {1'b0, d1_den_ff[j]};
         d1_rem_in[j+1] = ge ? df[31:0] : r2[31:0];
         d1_nb_in[j+1]  = {d1_nb_ff[j][23:0], 1'b0};
         d1_quo_in[j+1] = {d1_quo_ff[j][23:0], ge};
         d1_sii_in[j+1] = d1_sii_ff[j];
         d1_ovf_in[j+1] = d1_ovf_ff[j];
         d1_den_in[j+1] = d1_den_ff[j];
         d1_ctx_in[j+1] = d1_ctx_ff[j];
      end
   end

   // square root of k, one root bit per stage
   always_comb begin
      logic [57:0]   tw;
      logic [33:0]   t;
      logic [24:0]   k;
      logic [P1+1:0] remn;
      logic [P1+1:0] trial;
      logic          ge;

      tw = 58'(d1_sii_ff[TN]) + Q24_HALF;
      t  = d1_ctx_ff[TN].enter ? 34'(d1_quo_ff[TN]) : tw[57:24];
      k  = Q24_ONE - t[24:0];
      q1_x_in[0]    = {1'b0, k, 24'b0};
      q1_rem_in[0]  = '0;
      q1_root_in[0] = '0;
      q1_tir_in[0]  = (d1_ctx_ff[TN].enter && d1_ovf_ff[TN]) || (t > 34'(Q24_ONE));
      q1_ctx_in[0]  = d1_ctx_ff[TN];
      for (int j = 0; j < P1; j++) begin
         remn  = {q1_rem_ff[j][P1-1:0], q1_x_ff[j][49:48]};
         trial = {q1_root_ff[j], 2'b01};
         ge    = remn >= trial;
         q1_rem_in[j+1]  = ge ? remn - trial : remn;
         q1_root_in[j+1] = {q1_root_ff[j][P1-2:0], ge};
         q1_x_in[j+1]    = {q1_x_ff[j][47:0], 2'b00};
         q1_tir_in[j+1]  = q1_tir_ff[j];
         q1_ctx_in[j+1]  = q1_ctx_ff[j];
      end
   end

   // stages 7 to 13: unnormalized direction and its squared length
   always_comb begin
      logic [61:0] v;
      logic [60:0] orall;
      logic [5:0]  pos;

      s7_ctx_in = q1_ctx_ff[P1];
      s7_tir_in = q1_tir_ff[P1];
      s7_q_in   = q1_root_ff[P1];
      s7_iq_in  = 41'(q1_ctx_ff[P1].idx) * 41'(q1_root_ff[P1]);
      s7_ic_in  = 41'(q1_ctx_ff[P1].idx) * 41'(q1_ctx_ff[P1].c);
      for (int i = 0; i < 3; i++) begin
         s7_idd_in[i] = 33'($signed({1'b0, q1_ctx_ff[P1].idx}) * $signed(q1_ctx_ff[P1].d[i]));
      end

      s8_n_in   = s7_ctx_ff.n;
      s8_tir_in = s7_tir_ff;
      s8_w_in   = s7_ctx_ff.enter ? 44'(s7_ctx_ff.c) - 44'(s7_iq_ff[40:12])
                                  : 44'(s7_ic_ff) - 44'({s7_q_ff, 12'b0});
      for (int i = 0; i < 3; i++) begin
         s8_dt_in[i] = s7_ctx_ff.enter ? 46'($signed({s7_ctx_ff.d[i], 24'b0}))
                                       : 46'($signed({s7_idd_ff[i], 12'b0}));
      end

      s9_tir_in = s8_tir_ff;
      s9_dt_in  = s8_dt_ff;
      for (int i = 0; i < 3; i++) begin
         s9_wn_in[i] = 61'($signed(s8_w_ff) * $signed(s8_n_ff[i]));
      end

      s10_tir_in = s9_tir_ff;
      for (int i = 0; i < 3; i++) begin
         v = 62'($signed(s9_wn_ff[i])) + 62'($signed(s9_dt_ff[i]));
         s10_neg_in[i] = v[61];
         s10_mag_in[i] = v[61] ? 61'(-v) : v[60:0];
      end

      orall = s10_mag_ff[0] | s10_mag_ff[1] | s10_mag_ff[2];
      pos   = '0;
      for (int b = 0; b < 61; b++) begin
         if (orall[b]) begin
            pos = 6'(b);
         end
      end
      s11_sh_in   = (pos >= 6'd30) ? pos - 6'd29 : 6'd0;
      s11_zero_in = orall == '0;
      s11_tir_in  = s10_tir_ff;
      s11_neg_in  = s10_neg_ff;
      s11_mag_in  = s10_mag_ff;

      s12_tir_in  = s11_tir_ff;
      s12_zero_in = s11_zero_ff;
      s12_neg_in  = s11_neg_ff;
      for (int i = 0; i < 3; i++) begin
         s12_m_in[i] = 30'(s11_mag_ff[i] >> s11_sh_ff);
      end

      s13_tir_in  = s12_tir_ff;
      s13_zero_in = s12_zero_ff;
      s13_neg_in  = s12_neg_ff;
      s13_m_in    = s12_m_ff;
      for (int i = 0; i < 3; i++) begin
         s13_sq_in[i] = 60'(s12_m_ff[i]) * 60'(s12_m_ff[i]);
      end
   end

   // square root of the squared length, one root bit per stage
   always_comb begin
      logic [P2+1:0] remn;
      logic [P2+1:0] trial;
      logic          ge;

      q2_x_in[0]    = 62'(s13_sq_ff[0]) + 62'(s13_sq_ff[1]) + 62'(s13_sq_ff[2]);
      q2_rem_in[0]  = '0;
      q2_root_in[0] = '0;
      q2_tir_in[0]  = s13_tir_ff;
      q2_zero_in[0] = s13_zero_ff;
      q2_neg_in[0]  = s13_neg_ff;
      q2_m_in[0]    = s13_m_ff;
      for (int j = 0; j < P2; j++) begin
         remn  = {q2_rem_ff[j][P2-1:0], q2_x_ff[j][61:60]};
         trial = {q2_root_ff[j], 2'b01};
         ge    = remn >= trial;
         q2_rem_in[j+1]  = ge ? remn - trial : remn;
         q2_root_in[j+1] = {q2_root_ff[j][P2-2:0], ge};
         q2_x_in[j+1]    = {q2_x_ff[j][59:0], 2'b00};
         q2_tir_in[j+1]  = q2_tir_ff[j];
         q2_zero_in[j+1] = q2_zero_ff[j];
         q2_neg_in[j+1]  = q2_neg_ff[j];
         q2_m_in[j+1]    = q2_m_ff[j];
      end
   end

   // component dividers, rounded, one quotient bit per stage
   always_comb begin
      logic [NW-1:0] num;
      logic [31:0]   r2;
      logic [31:0]   df;
      logic          ge;

      d2_len_in[0]  = q2_root_ff[P2];
      d2_tir_in[0]  = q2_tir_ff[P2];
      d2_zero_in[0] = q2_zero_ff[P2] || (q2_root_ff[P2] == '0);
      d2_neg_in[0]  = q2_neg_ff[P2];
      d2_quo_in[0]  = '0;
      for (int i = 0; i < 3; i++) begin
         num = (NW'(q2_m_ff[P2][i]) << FRAC_BITS) + NW'(q2_root_ff[P2][P2-1:1]);
         d2_rem_in[0][i] = 31'(num >> FN);
         d2_nb_in[0][i]  = num[FN-1:0];
      end
      for (int j = 0; j < FN; j++) begin
         for (int i = 0; i < 3; i++) begin
            r2 = {d2_rem_ff[j][i], d2_nb_ff[j][i][FN-1]};
            df = r2 - {1'b0, d2_len_ff[j]};
            ge = r2 >= {1'b0, d2_len_ff[j]};
            d2_rem_in[j+1][i] = ge ? df[30:0] : r2[30:0];
            d2_nb_in[j+1][i]  = {d2_nb_ff[j][i][FN-2:0], 1'b0};
            d2_quo_in[j+1][i] = {d2_quo_ff[j][i][FN-2:0], ge};
         end
         d2_len_in[j+1]  = d2_len_ff[j];
         d2_tir_in[j+1]  = d2_tir_ff[j];
         d2_zero_in[j+1] = d2_zero_ff[j];
         d2_neg_in[j+1]  = d2_neg_ff[j];
      end
   end

   // saturation into the output word
   always_comb begin
      logic [63:0] m;

      out_tir_in = d2_tir_ff[FN];
      for (int i = 0; i < 3; i++) begin
         m = 64'(d2_quo_ff[FN][i]);
         if (d2_tir_ff[FN] || d2_zero_ff[FN]) begin
            out_v_in[i] = '0;
         end else if (d2_neg_ff[FN][i]) begin
            out_v_in[i] = (m > 64'd32768) ? 16'h8000 : 16'(-m);
         end else begin
            out_v_in[i] = (m > 64'd32767) ? 16'h7fff : m[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff    <= s1_p_in;
         s1_d_ff    <= s1_d_in;
         s1_n_ff    <= s1_n_in;
         s1_idx_ff  <= s1_idx_in;
         s1_idx2_ff <= s1_idx2_in;
         s2_ctx_ff  <= s2_ctx_in;
         s2_idx2_ff <= s2_idx2_in;
         s3_ctx_ff  <= s3_ctx_in;
         s3_idx2_ff <= s3_idx2_in;
         s3_cch_ff  <= s3_cch_in;
         s4_ctx_ff  <= s4_ctx_in;
         s4_idx2_ff <= s4_idx2_in;
         s4_s_ff    <= s4_s_in;
         s4_sidx_ff <= s4_sidx_in;
         s4_ovf_ff  <= s4_ovf_in;
         d1_rem_ff  <= d1_rem_in;
         d1_nb_ff   <= d1_nb_in;
         d1_quo_ff  <= d1_quo_in;
         d1_sii_ff  <= d1_sii_in;
         d1_ovf_ff  <= d1_ovf_in;
         d1_den_ff  <= d1_den_in;
         d1_ctx_ff  <= d1_ctx_in;
         q1_x_ff    <= q1_x_in;
         q1_rem_ff  <= q1_rem_in;
         q1_root_ff <= q1_root_in;
         q1_tir_ff  <= q1_tir_in;
         q1_ctx_ff  <= q1_ctx_in;
         s7_ctx_ff  <= s7_ctx_in;
         s7_tir_ff  <= s7_tir_in;
         s7_iq_ff   <= s7_iq_in;
         s7_ic_ff   <= s7_ic_in;
         s7_q_ff    <= s7_q_in;
         s7_idd_ff  <= s7_idd_in;
         s8_n_ff    <= s8_n_in;
         s8_tir_ff  <= s8_tir_in;
         s8_w_ff    <= s8_w_in;
         s8_dt_ff   <= s8_dt_in;
         s9_tir_ff  <= s9_tir_in;
         s9_wn_ff   <= s9_wn_in;
         s9_dt_ff   <= s9_dt_in;
         s10_tir_ff <= s10_tir_in;
         s10_neg_ff <= s10_neg_in;
         s10_mag_ff <= s10_mag_in;
         s11_tir_ff <= s11_tir_in;
         s11_zero_ff <= s11_zero_in;
         s11_neg_ff <= s11_neg_in;
         s11_mag_ff <= s11_mag_in;
         s11_sh_ff  <= s11_sh_in;
         s12_tir_ff <= s12_tir_in;
         s12_zero_ff <= s12_zero_in;
         s12_neg_ff <= s12_neg_in;
         s12_m_ff   <= s12_m_in;
         s13_tir_ff <= s13_tir_in;
         s13_zero_ff <= s13_zero_in;
         s13_neg_ff <= s13_neg_in;
         s13_m_ff   <= s13_m_in;
         s13_sq_ff  <= s13_sq_in;
         q2_x_ff    <= q2_x_in;
         q2_rem_ff  <= q2_rem_in;
         q2_root_ff <= q2_root_in;
         q2_tir_ff  <= q2_tir_in;
         q2_zero_ff <= q2_zero_in;
         q2_neg_ff  <= q2_neg_in;
         q2_m_ff    <= q2_m_in;
         d2_rem_ff  <= d2_rem_in;
         d2_nb_ff   <= d2_nb_in;
         d2_quo_ff  <= d2_quo_in;
         d2_len_ff  <= d2_len_in;
         d2_tir_ff  <= d2_tir_in;
         d2_zero_ff <= d2_zero_in;
         d2_neg_ff  <= d2_neg_in;
         out_v_ff   <= out_v_in;
         out_tir_ff <= out_tir_in;
      end
   end

   assign rsp_ch.valid            = vld_ff[LAT-1];
   assign rsp_ch.out_x            = out_v_ff[0];
   assign rsp_ch.out_y            = out_v_ff[1];
   assign rsp_ch.out_z            = out_v_ff[2];
   assign rsp_ch.total_reflection = out_tir_ff;

   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.total_reflection |->
         rsp_ch.out_x == '0 && rsp_ch.out_y == '0 && rsp_ch.out_z == '0)
      else $error("total reflection word with nonzero vector");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result word valid right after reset");

endmodule

`default_nettype wire
